// File: sv/edm_pkg.sv
// Shared types, constants and helpers for the edit distance match counter.
package edm_pkg;

  localparam int unsigned CharW  = 21;
  localparam int unsigned DistW  = 8;
  localparam int unsigned CountW = 32;
  localparam int unsigned DataW  = 32;
  localparam int unsigned AddrW  = 3;

  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};
  localparam logic [DistW-1:0] ThresholdRst = 8'd2;

  typedef enum logic [0:0] {
    RegThreshold = 1'b0
  } reg_idx_e;

  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic [CharW-1:0] ch;
    logic [DistW-1:0] left;
    logic [DistW-1:0] diag;
  } tok_t;

  function automatic logic [DistW-1:0] sat_inc(input logic [DistW-1:0] x);
    sat_inc = (x == DistMax) ? DistMax : x + DistW'(1);
  endfunction

endpackage

// File: sv/edm_in_if.sv
// Input word channel: query or dictionary character.
interface edm_in_if;
  import edm_pkg::*;

  logic             valid;
  logic             ready;
  logic             mode;
  logic [CharW-1:0] character;
  logic             last;

  modport source (output valid, mode, character, last, input ready);
  modport sink (input valid, mode, character, last, output ready);
endinterface

// File: sv/edm_out_if.sv
// Output word channel: distance, match flag and running match count.
interface edm_out_if;
  import edm_pkg::*;

  logic              valid;
  logic              ready;
  logic [DistW-1:0]  distance;
  logic              within_res;
  logic [CountW-1:0] match_count;

  modport source (output valid, distance, within_res, match_count, input ready);
  modport sink (input valid, distance, within_res, match_count, output ready);
endinterface

// File: sv/edm_cell.sv
// One DP cell: holds one query character and one row entry, updates per dictionary character.
module edm_cell #(
  parameter int unsigned IDX   = 1,
  parameter int unsigned LEN_W = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic [LEN_W-1:0]     qlen_i,
  input  logic                 wr_en_i,
  input  logic [edm_pkg::CharW-1:0] wr_char_i,
  input  edm_pkg::tok_t        tok_i,
  output edm_pkg::tok_t        tok_o
);
  import edm_pkg::*;

  localparam logic [DistW-1:0] InitVal = (IDX > 255) ? DistMax : DistW'(IDX);

  logic [CharW-1:0] qchar_q;
  logic [DistW-1:0] dp_q, dp_d;
  logic [DistW-1:0] old_v, ins_v, del_v, sub_v, m_v;
  logic [DistW:0]   sub_sum;
  logic             en;
  tok_t             tok_q, tok_d;

  always_comb begin
    en      = tok_i.valid && (LEN_W'(IDX) <= qlen_i);
    old_v   = tok_i.first ? InitVal : dp_q;
    sub_sum = {1'b0, tok_i.diag} + {{DistW{1'b0}}, (qchar_q != tok_i.ch)};
    sub_v   = sub_sum[DistW] ? DistMax : sub_sum[DistW-1:0];
    ins_v   = sat_inc(old_v);
    del_v   = sat_inc(tok_i.left);
    m_v     = (sub_v < ins_v) ? sub_v : ins_v;
    dp_d    = (del_v < m_v) ? del_v : m_v;
    tok_d   = tok_i;
    if (en) begin
      tok_d.left = dp_d;
      tok_d.diag = old_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      qchar_q <= wr_char_i;
    end
    if (adv_i && en) begin
      dp_q <= dp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else if (adv_i) begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// File: sv/edit_distance_match_counter.sv
// Top level: query loader, systolic row of DP cells and match counter.
// A word's result passes from the front register through every cell to the output register.
// Throughput: one dictionary character per cycle while the output is not stalled; a query
// character waits until the front register and cell row hold no word in flight.
// Reset: query empty, threshold 2, match count 0, cell tokens cleared; cell row entries need no clearing.
module edit_distance_match_counter #(
  parameter int unsigned MAX_QUERY_LEN = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  edm_in_if.sink                   in_i,
  edm_out_if.source                out_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [edm_pkg::AddrW-1:0] paddr,
  input  logic [edm_pkg::DataW-1:0] pwdata,
  output logic [edm_pkg::DataW-1:0] prdata,
  output logic                     pready
);
  import edm_pkg::*;

  localparam int unsigned LenW = $clog2(MAX_QUERY_LEN + 1);

  logic [DistW-1:0]  threshold_q;
  logic [LenW-1:0]   qlen_q, qlen_d, qlen_eff;
  logic              loading_q;
  logic [DistW-1:0]  wp_q;
  logic [CountW-1:0] count_q, count_d;
  logic              out_valid_q;
  logic [DistW-1:0]  dist_q;
  logic              within_q;

  tok_t              chain [MAX_QUERY_LEN+1];
  tok_t              front_q;
  logic [MAX_QUERY_LEN:0] busy_vec;
  logic              busy, adv, acc, q_wr, within_v;
  tok_t              tail;

  assign pready = 1'b1;
  assign prdata = {{(DataW-DistW){1'b0}}, threshold_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= ThresholdRst;
    end else if (psel && penable && pwrite && (reg_idx_e'(paddr[2]) == RegThreshold)) begin
      threshold_q <= pwdata[DistW-1:0];
    end
  end

  always_comb begin
    for (int k = 0; k <= MAX_QUERY_LEN; k++) begin
      busy_vec[k] = chain[k].valid;
    end
  end

  assign busy     = |busy_vec;
  assign adv      = !out_valid_q || out_o.ready;
  assign in_i.ready = adv && (in_i.mode || !busy);
  assign acc      = in_i.valid && in_i.ready;
  assign q_wr     = acc && !in_i.mode;
  assign qlen_eff = loading_q ? qlen_q : '0;
  assign qlen_d   = (qlen_eff < LenW'(MAX_QUERY_LEN)) ? qlen_eff + LenW'(1) : qlen_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qlen_q    <= '0;
      loading_q <= 1'b1;
      wp_q      <= '0;
    end else if (acc) begin
      if (!in_i.mode) begin
        qlen_q    <= qlen_d;
        loading_q <= !in_i.last;
        wp_q      <= '0;
      end else begin
        wp_q <= in_i.last ? '0 : sat_inc(wp_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
    end else if (adv) begin
      front_q.valid <= acc && in_i.mode;
      front_q.first <= (wp_q == '0);
      front_q.last  <= in_i.last;
      front_q.ch    <= in_i.character;
      front_q.left  <= sat_inc(wp_q);
      front_q.diag  <= wp_q;
    end
  end

  assign chain[0] = front_q;

  for (genvar k = 1; k <= MAX_QUERY_LEN; k++) begin : g_cell
    edm_cell #(
      .IDX   (k),
      .LEN_W (LenW)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .adv_i     (adv),
      .qlen_i    (qlen_q),
      .wr_en_i   (q_wr && (qlen_eff == LenW'(k - 1))),
      .wr_char_i (in_i.character),
      .tok_i     (chain[k-1]),
      .tok_o     (chain[k])
    );
  end

  assign tail     = chain[MAX_QUERY_LEN];
  assign within_v = (tail.left <= threshold_q);
  assign count_d  = (within_v && (count_q != {CountW{1'b1}})) ? count_q + CountW'(1) : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_wr && in_i.last) begin
        count_q <= '0;
      end else if (adv && tail.valid && tail.last) begin
        count_q <= count_d;
      end
      if (adv) begin
        out_valid_q <= tail.valid && tail.last;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && tail.valid && tail.last) begin
      dist_q   <= tail.left;
      within_q <= within_v;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.distance    = dist_q;
  assign out_o.within_res  = within_q;
  assign out_o.match_count = count_q;

endmodule

// File: verif/edit_distance_match_counter_test.sv
// Testbench for the edit distance match counter: predicts and checks every distance result.
`timescale 1ns / 100ps

module edit_distance_match_counter_test;
  import edm_pkg::*;

  localparam int unsigned QueryMax   = 32;
  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned PhaseItems = 210;
  localparam logic [CharW-1:0] CharMax = 21'h10FFFF;
  localparam logic [CharW-1:0] CharA = 21'h61;
  localparam logic [CharW-1:0] CharB = 21'h62;
  localparam logic [CharW-1:0] CharC = 21'h63;
  localparam logic [CharW-1:0] CharD = 21'h64;
  localparam logic [CharW-1:0] CharE = 21'h65;
  localparam logic [CharW-1:0] CharF = 21'h66;
  localparam logic [CharW-1:0] CharQ = 21'h71;
  localparam logic [CharW-1:0] CharX = 21'h78;
  localparam logic [CharW-1:0] Alphabet [6] = '{CharA, CharB, CharC, CharD, 21'h0, CharMax};

  typedef logic [CharW-1:0] text_t[$];

  typedef struct packed {
    logic [DistW-1:0]  distance;
    logic              within_res;
    logic [CountW-1:0] match_count;
  } score_t;

  class match_scoreboard;
    logic [CharW-1:0]  query[QueryMax];
    int unsigned       query_len = 0;
    bit                loading = 1'b1;
    logic [DistW-1:0]  cost_row[QueryMax+1];
    logic [DistW-1:0]  word_pos = '0;
    logic [CountW-1:0] match_total = '0;
    logic [DistW-1:0]  threshold = ThresholdRst;
    score_t            expected_q[$];
    int unsigned       errors = 0;
    int unsigned       scores = 0;
    int unsigned       hits = 0;
    int unsigned       saturated = 0;

    function new();
      restart_row();
    endfunction

    function void restart_row();
      for (int i = 0; i <= QueryMax; i++) cost_row[i] = DistW'(i);
    endfunction

    function logic [DistW-1:0] bump(logic [DistW-1:0] x);
      return (x == DistMax) ? x : x + 1'b1;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void report(string msg);
      if (errors < 100) $display("%0t mismatch: %s", $time, msg);
      errors++;
    endfunction

    function void note_input(logic mode, logic [CharW-1:0] ch, logic last);
      logic [DistW-1:0] diag;
      logic [DistW-1:0] best;
      logic [DistW:0]   sub;
      score_t           s;
      if (!mode) begin
        if (!loading) begin
          query_len = 0;
          loading = 1'b1;
        end
        if (query_len < QueryMax) begin
          query[query_len] = ch;
          query_len++;
        end
        if (last) begin
          loading = 1'b0;
          match_total = '0;
        end
        word_pos = '0;
        restart_row();
        return;
      end
      if (word_pos == 0) restart_row();
      diag = cost_row[0];
      word_pos = bump(word_pos);
      cost_row[0] = word_pos;
      for (int i = 1; i <= query_len; i++) begin
        sub = {1'b0, diag} + {{DistW{1'b0}}, query[i-1] != ch};
        best = (sub > DistMax) ? DistMax : sub[DistW-1:0];
        if (bump(cost_row[i]) < best) best = bump(cost_row[i]);
        if (bump(cost_row[i-1]) < best) best = bump(cost_row[i-1]);
        diag = cost_row[i];
        cost_row[i] = best;
      end
      if (!last) return;
      s.distance = cost_row[query_len];
      s.within_res = (cost_row[query_len] <= threshold);
      word_pos = '0;
      if (s.within_res && match_total != '1) match_total++;
      s.match_count = match_total;
      expected_q.insert(expected_q.size(), s);
    endfunction

    function void check_result(score_t got);
      score_t exp;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result distance %0d", got.distance));
        return;
      end
      exp = expected_q.pop_front();
      scores++;
      if (got.within_res) hits++;
      if (got.distance == DistMax) saturated++;
      if (got.distance !== exp.distance)
        report($sformatf("distance %0d, want %0d", got.distance, exp.distance));
      if (got.within_res !== exp.within_res)
        report($sformatf("within_res %0b, want %0b", got.within_res, exp.within_res));
      if (got.match_count !== exp.match_count)
        report($sformatf("match_count %0d, want %0d", got.match_count, exp.match_count));
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  edm_in_if  in_if ();
  edm_out_if out_if ();

  edit_distance_match_counter #(.MAX_QUERY_LEN(QueryMax)) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  match_scoreboard sb;
  bit              steady = 1'b0;
  int unsigned     cycles = 0;
  int unsigned     items_sent = 0;
  int unsigned     queries = 0;
  text_t           cur_query;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) out_if.ready <= steady || ($urandom_range(99) >= 35);

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) sb.note_input(in_if.mode, in_if.character, in_if.last);
      if (out_if.valid && out_if.ready)
        sb.check_result('{out_if.distance, out_if.within_res, out_if.match_count});
    end
  end

  function automatic logic [CharW-1:0] pick_char();
    if ($urandom_range(99) < 70) return Alphabet[$urandom_range(5)];
    return CharW'($urandom_range(CharMax));
  endfunction

  task automatic send_char(logic mode, logic [CharW-1:0] ch, logic last);
    if (!steady && $urandom_range(99) < 35) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while (!steady && $urandom_range(99) < 35);
    end
    in_if.valid     <= 1'b1;
    in_if.mode      <= mode;
    in_if.character <= ch;
    in_if.last      <= last;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
  endtask

  task automatic send_text(logic mode, text_t s, bit complete);
    foreach (s[k]) send_char(mode, s[k], complete && (k == s.size() - 1));
  endtask

  task automatic send_word(bit complete);
    text_t       w;
    int unsigned pos;
    if ($urandom_range(99) < 65) begin
      w = cur_query;
      repeat ($urandom_range(4)) begin
        pos = $urandom_range(w.size());
        case ($urandom_range(2))
          0: w.insert(pos, pick_char());
          1: if (pos < w.size()) w.delete(pos);
          default: if (pos < w.size()) w[pos] = pick_char();
        endcase
      end
    end else begin
      repeat ($urandom_range(1, 10)) w.insert(w.size(), pick_char());
    end
    if (w.size() == 0) w.insert(w.size(), pick_char());
    send_text(1'b1, w, complete);
  endtask

  task automatic send_query(int unsigned len, bit split);
    text_t       q;
    int unsigned cut;
    repeat (len) q.insert(q.size(), pick_char());
    cur_query = q;
    if (split && len > 1) begin
      cut = $urandom_range(1, len - 1);
      send_text(1'b0, q[0:cut-1], 1'b0);
      send_word(1'b1);
      send_text(1'b0, q[cut:$], 1'b1);
    end else begin
      send_text(1'b0, q, 1'b1);
    end
    queries++;
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (QueryMax + 8) @(posedge clk_i);
  endtask

  task automatic reg_write(reg_idx_e idx, logic [DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(4 * int'(idx));
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic reg_read(reg_idx_e idx, output logic [DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= AddrW'(4 * int'(idx));
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    value = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [DistW-1:0] thr_plan [5];
    logic [DataW-1:0] readback;
    text_t            long_word;
    int unsigned      goal;
    int unsigned      r;
    bit               paused;
    sb = new();
    paused = 1'b0;
    thr_plan = '{8'd0, 8'd255, 8'd1, 8'd3, 8'($urandom_range(4, 254))};
    rst_ni          <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.mode      <= 1'b0;
    in_if.character <= '0;
    in_if.last      <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // word against the empty query, then a word in the middle of loading a query
    send_text(1'b1, '{CharA, CharB}, 1'b1);
    send_text(1'b0, '{21'h0}, 1'b0);
    send_text(1'b1, '{CharX}, 1'b1);
    send_text(1'b0, '{CharMax, CharC}, 1'b1);
    queries++;
    send_text(1'b1, '{21'h0, CharMax, CharC}, 1'b1);
    send_text(1'b1, '{CharMax, CharC}, 1'b1);
    send_text(1'b1, '{CharA, CharB, CharD, CharE, CharF}, 1'b1);
    // drop a partial word with a new query
    send_text(1'b1, '{21'h0}, 1'b0);
    send_text(1'b0, '{CharQ}, 1'b1);
    queries++;
    cur_query = '{CharQ};
    send_text(1'b1, '{CharQ}, 1'b1);
    send_text(1'b1, '{CharQ, CharQ, CharQ}, 1'b1);

    for (int p = 0; p < 5; p++) begin
      wait_idle();
      reg_write(RegThreshold, DataW'(thr_plan[p]));
      sb.threshold = thr_plan[p];
      reg_read(RegThreshold, readback);
      if (readback !== DataW'(thr_plan[p]))
        sb.report($sformatf("threshold reads %0d, want %0d", readback, thr_plan[p]));
      steady = (p == 2);
      goal = items_sent + PhaseItems;
      if (p == 1) begin
        send_query(1, 1'b0);
        long_word.delete();
        repeat (258) long_word.insert(long_word.size(), pick_char());
        send_text(1'b1, long_word, 1'b1);
      end
      while (items_sent < goal) begin
        if (p == 3 && !paused && items_sent >= goal - PhaseItems / 2) begin
          wait_idle();
          paused = 1'b1;
        end
        r = $urandom_range(99);
        if (r < 10) begin
          send_query(($urandom_range(99) < 15) ? $urandom_range(QueryMax + 1, QueryMax + 4)
                                               : $urandom_range(1, 8),
                     $urandom_range(99) < 20);
        end else if (r < 16) begin
          send_word(1'b0);
          send_query($urandom_range(1, 6), 1'b0);
        end else begin
          send_word(1'b1);
        end
      end
    end
    steady = 1'b0;

    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (QueryMax + 8) @(posedge clk_i);
    $display("Sent %0d characters in %0d queries; checked %0d distances,",
             items_sent, queries, sb.scores);
    $display("%0d within threshold, %0d saturated; thresholds 2, 0, 255, 1, 3 and %0d used.",
             sb.hits, sb.saturated, thr_plan[4]);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
